### rtl/dapsc_pkg.sv
// Shared types and constants for the two-axis PID servo command block.
// Used by dapsc_pid_axis, dapsc_channel and dual_axis_pid_servo_command.
`default_nettype none

package dapsc_pkg;

  // gain format: unsigned with this many fraction bits
  localparam int GAIN_FRAC_BITS = 12;

  // width of the gain-weighted sum (three 34-bit products plus growth)
  localparam int SUM_W = 36;

  // added to a negative sum so the shift truncates toward zero
  localparam logic [SUM_W-1:0] TRUNC_BIAS = SUM_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

  // servo channel mapping
  localparam int CHAN_W = 11;
  localparam logic [CHAN_W-1:0] CHAN_NEUTRAL   = 11'd1000;
  localparam logic [CHAN_W-1:0] CHAN_MIN       = 11'd200;
  localparam logic [CHAN_W-1:0] CHAN_MAX       = 11'd1800;
  localparam logic [CHAN_W-1:0] PITCH_POS_OFF  = 11'd1160;
  localparam logic [CHAN_W-1:0] PITCH_NEG_OFF  = 11'd805;
  localparam logic [CHAN_W-1:0] YAW_POS_OFF    = 11'd1110;
  localparam logic [CHAN_W-1:0] YAW_NEG_OFF    = 11'd890;

  // configuration register map
  typedef enum logic [2:0] {
    REG_PITCH_KP       = 3'd0,
    REG_PITCH_KI       = 3'd1,
    REG_PITCH_KD       = 3'd2,
    REG_YAW_KP         = 3'd3,
    REG_YAW_KI         = 3'd4,
    REG_YAW_KD         = 3'd5,
    REG_INTEGRAL_LIMIT = 3'd6,
    REG_AIM_THRESHOLD  = 3'd7
  } cfg_reg_t;

  // register reset values
  localparam logic [15:0]        RST_PITCH_KP       = 16'd27034;
  localparam logic [15:0]        RST_PITCH_KI       = 16'd74;
  localparam logic [15:0]        RST_PITCH_KD       = 16'd1761;
  localparam logic [15:0]        RST_YAW_KP         = 16'd32195;
  localparam logic [15:0]        RST_YAW_KI         = 16'd414;
  localparam logic [15:0]        RST_YAW_KD         = 16'd1393;
  localparam logic [14:0]        RST_INTEGRAL_LIMIT = 15'd640;
  localparam logic signed [15:0] RST_AIM_THRESHOLD  = 16'sd20;

  // gain set of one axis
  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
  } pid_gains_t;

endpackage

`default_nettype wire

### rtl/dapsc_pid_axis.sv
// One PID axis: accumulator and last-error registers plus the combinational
// step that forms the saturated int16 command. Depends on dapsc_pkg.
`default_nettype none

module dapsc_pid_axis
  import dapsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire logic signed [15:0] err,
  input  wire pid_gains_t         gains,
  input  wire logic [14:0]        integral_limit,
  output logic signed [15:0]      cmd,
  output logic signed [15:0]      last_error
);

  logic signed [15:0] accum_r, accum_nxt;
  logic signed [15:0] last_r;

  logic signed [16:0] acc_sum;
  logic signed [16:0] acc_clamped;
  logic signed [16:0] lim_pos;
  logic signed [16:0] lim_neg;
  logic signed [16:0] slope;
  logic signed [33:0] p_prod;
  logic signed [33:0] i_prod;
  logic signed [33:0] d_prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_biased;
  logic signed [SUM_W-1:0] quot;

  // accumulate and clamp to +/- limit
  always_comb begin
    acc_sum = 17'(err) + 17'(accum_r);
    lim_pos = $signed({2'b00, integral_limit});
    lim_neg = -lim_pos;
    if (acc_sum > lim_pos) begin
      acc_clamped = lim_pos;
    end else if (acc_sum < lim_neg) begin
      acc_clamped = lim_neg;
    end else begin
      acc_clamped = acc_sum;
    end
    accum_nxt = acc_clamped[15:0];
    slope     = 17'(err) - 17'(last_r);
  end

  // gain products, 17x17 signed each
  assign p_prod = $signed({1'b0, gains.kp}) * $signed(17'(err));
  assign i_prod = $signed({1'b0, gains.ki}) * acc_clamped;
  assign d_prod = $signed({1'b0, gains.kd}) * slope;

  // sum, truncate toward zero, saturate to int16
  always_comb begin
    sum        = SUM_W'(p_prod) + SUM_W'(i_prod) + SUM_W'(d_prod);
    sum_biased = sum[SUM_W-1] ? sum + $signed(TRUNC_BIAS) : sum;
    quot       = sum_biased >>> GAIN_FRAC_BITS;
    if ((&quot[SUM_W-1:15]) || !(|quot[SUM_W-1:15])) begin
      cmd = quot[15:0];
    end else if (quot[SUM_W-1]) begin
      cmd = 16'sh8000;
    end else begin
      cmd = 16'sh7fff;
    end
  end

  // axis state, updated once per tracked tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      last_r  <= '0;
    end else if (step) begin
      accum_r <= accum_nxt;
      last_r  <= err;
    end
  end

  assign last_error = last_r;

endmodule

`default_nettype wire

### rtl/dapsc_channel.sv
// Maps a signed int16 command to a servo channel value: negate, add the
// dead-band offset for its sign, clamp to the channel range. Uses dapsc_pkg.
`default_nettype none

module dapsc_channel
  import dapsc_pkg::*;
(
  input  wire logic signed [15:0]  cmd,
  input  wire logic [CHAN_W-1:0]   pos_off,
  input  wire logic [CHAN_W-1:0]   neg_off,
  output logic [CHAN_W-1:0]        chan
);

  logic signed [17:0] neg_cmd;
  logic signed [17:0] shifted;

  // negate wide, apply sign-dependent offset, clamp
  always_comb begin
    neg_cmd = -18'(cmd);
    if (neg_cmd > 18'sd0) begin
      shifted = neg_cmd + $signed({7'd0, pos_off});
    end else if (neg_cmd == 18'sd0) begin
      shifted = $signed({7'd0, CHAN_NEUTRAL});
    end else begin
      shifted = neg_cmd + $signed({7'd0, neg_off});
    end
    if (shifted > $signed({7'd0, CHAN_MAX})) begin
      chan = CHAN_MAX;
    end else if (shifted < $signed({7'd0, CHAN_MIN})) begin
      chan = CHAN_MIN;
    end else begin
      chan = shifted[CHAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/dual_axis_pid_servo_command.sv
// Two-axis PID servo command block: top level with the input and result
// registers and the configuration registers. Depends on dapsc_pkg,
// dapsc_pid_axis and dapsc_channel.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one control tick per transfer:
//   mode, target-valid, x/y tracking errors and manual pitch/yaw. The result
//   channel (out_valid/out_ready) returns exactly one item per tick: a
//   command-valid bit, pitch and yaw servo channel values and the aim flag.
//   A tick is latched into an input register; once the result register is free
//   or draining, the PID step of both axes, the channel mapping and the state
//   update run in one pass into the result register. Throughput is one tick per
//   cycle while the receiver does not stall, set by the single pass from the
//   input register through the gain multipliers to the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more tick; in_ready drops only when both are
//   full. Reset (rst_n low, synchronous) clears both registers, the
//   accumulators and last errors, and loads the default gains, integral
//   limit and aim threshold. Configuration writes (cfg_wr_en) take effect at
//   the next edge and should be made only while no tick is in flight.
`default_nettype none

module dual_axis_pid_servo_command
  import dapsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_manual_mode,
  input  wire logic               in_target_valid,
  input  wire logic signed [15:0] in_error_x,
  input  wire logic signed [15:0] in_error_y,
  input  wire logic signed [15:0] in_manual_pitch,
  input  wire logic signed [15:0] in_manual_yaw,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_command_valid,
  output logic [CHAN_W-1:0]       out_pitch_channel,
  output logic [CHAN_W-1:0]       out_yaw_channel,
  output logic                    out_aim_ok
);

  // configuration registers
  pid_gains_t         pitch_gains_r;
  pid_gains_t         yaw_gains_r;
  logic [14:0]        integral_limit_r;
  logic signed [15:0] aim_threshold_r;

  // input register
  logic               in_valid_r;
  logic               manual_r;
  logic               target_r;
  logic signed [15:0] error_x_r;
  logic signed [15:0] error_y_r;
  logic signed [15:0] manual_pitch_r;
  logic signed [15:0] manual_yaw_r;

  // result register
  logic               out_valid_r;
  logic               command_valid_r, command_valid_nxt;
  logic [CHAN_W-1:0]  pitch_channel_r, pitch_channel_nxt;
  logic [CHAN_W-1:0]  yaw_channel_r, yaw_channel_nxt;
  logic               aim_ok_r, aim_ok_nxt;

  logic               advance;
  logic               pid_step;
  logic signed [15:0] pitch_pid_cmd;
  logic signed [15:0] yaw_pid_cmd;
  logic signed [15:0] pitch_last;
  logic signed [15:0] yaw_last;
  logic signed [15:0] pitch_cmd;
  logic signed [15:0] yaw_cmd;
  logic [CHAN_W-1:0]  pitch_chan;
  logic [CHAN_W-1:0]  yaw_chan;
  logic signed [15:0] aim_error;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_gains_r    <= '{kp: RST_PITCH_KP, ki: RST_PITCH_KI, kd: RST_PITCH_KD};
      yaw_gains_r      <= '{kp: RST_YAW_KP, ki: RST_YAW_KI, kd: RST_YAW_KD};
      integral_limit_r <= RST_INTEGRAL_LIMIT;
      aim_threshold_r  <= RST_AIM_THRESHOLD;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PITCH_KP:       pitch_gains_r.kp <= cfg_data;
        REG_PITCH_KI:       pitch_gains_r.ki <= cfg_data;
        REG_PITCH_KD:       pitch_gains_r.kd <= cfg_data;
        REG_YAW_KP:         yaw_gains_r.kp   <= cfg_data;
        REG_YAW_KI:         yaw_gains_r.ki   <= cfg_data;
        REG_YAW_KD:         yaw_gains_r.kd   <= cfg_data;
        REG_INTEGRAL_LIMIT: integral_limit_r <= cfg_data[14:0];
        REG_AIM_THRESHOLD:  aim_threshold_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: the tick moves on when the result slot is free or draining
  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign pid_step = advance && !manual_r && target_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      manual_r       <= in_manual_mode;
      target_r       <= in_target_valid;
      error_x_r      <= in_error_x;
      error_y_r      <= in_error_y;
      manual_pitch_r <= in_manual_pitch;
      manual_yaw_r   <= in_manual_yaw;
    end
  end

  // pid axes: error_y drives pitch, error_x drives yaw
  dapsc_pid_axis u_pitch_axis (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (pid_step),
    .err            (error_y_r),
    .gains          (pitch_gains_r),
    .integral_limit (integral_limit_r),
    .cmd            (pitch_pid_cmd),
    .last_error     (pitch_last)
  );

  dapsc_pid_axis u_yaw_axis (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (pid_step),
    .err            (error_x_r),
    .gains          (yaw_gains_r),
    .integral_limit (integral_limit_r),
    .cmd            (yaw_pid_cmd),
    .last_error     (yaw_last)
  );

  // command source: manual pass-through or pid output
  assign pitch_cmd = manual_r ? manual_pitch_r : pitch_pid_cmd;
  assign yaw_cmd   = manual_r ? manual_yaw_r   : yaw_pid_cmd;

  dapsc_channel u_pitch_chan (
    .cmd     (pitch_cmd),
    .pos_off (PITCH_POS_OFF),
    .neg_off (PITCH_NEG_OFF),
    .chan    (pitch_chan)
  );

  dapsc_channel u_yaw_chan (
    .cmd     (yaw_cmd),
    .pos_off (YAW_POS_OFF),
    .neg_off (YAW_NEG_OFF),
    .chan    (yaw_chan)
  );

  // result fields; aim uses the pitch error as it stands after this tick
  always_comb begin
    aim_error = target_r ? error_y_r : pitch_last;
    if (manual_r) begin
      command_valid_nxt = 1'b1;
      pitch_channel_nxt = pitch_chan;
      yaw_channel_nxt   = yaw_chan;
      aim_ok_nxt        = 1'b0;
    end else if (target_r) begin
      command_valid_nxt = 1'b1;
      pitch_channel_nxt = pitch_chan;
      yaw_channel_nxt   = yaw_chan;
      aim_ok_nxt        = (aim_error <= aim_threshold_r);
    end else begin
      command_valid_nxt = 1'b0;
      pitch_channel_nxt = CHAN_NEUTRAL;
      yaw_channel_nxt   = CHAN_NEUTRAL;
      aim_ok_nxt        = (aim_error <= aim_threshold_r);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      command_valid_r <= command_valid_nxt;
      pitch_channel_r <= pitch_channel_nxt;
      yaw_channel_r   <= yaw_channel_nxt;
      aim_ok_r        <= aim_ok_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_command_valid = command_valid_r;
  assign out_pitch_channel = pitch_channel_r;
  assign out_yaw_channel   = yaw_channel_r;
  assign out_aim_ok        = aim_ok_r;

endmodule

`default_nettype wire

### tb/tb_dual_axis_pid_servo_command.sv
// Self-checking testbench for dual_axis_pid_servo_command: directed and random
// control ticks, checked against a cycle-free model of the two PID axes.
// Depends on dapsc_pkg and the block's RTL only.
`default_nettype none

module tb_dual_axis_pid_servo_command;
  import dapsc_pkg::*;

  // channel mapping and gain fraction bits as the block is specified, plus bench limits
  localparam int CH_NEUTRAL  = 1000;
  localparam int CH_LOW      = 200;
  localparam int CH_HIGH     = 1800;
  localparam int PITCH_UP    = 1160;
  localparam int PITCH_DOWN  = 805;
  localparam int YAW_UP      = 1110;
  localparam int YAW_DOWN    = 890;
  localparam int FRAC_BITS   = 12;
  localparam int AX_PITCH    = 0;
  localparam int AX_YAW      = 1;
  localparam int STALL_LIMIT = 1000;
  localparam int EXP_DEPTH   = 4096;

  typedef struct packed {
    logic        manual;
    logic        tvalid;
    logic [15:0] ex;
    logic [15:0] ey;
    logic [15:0] mp;
    logic [15:0] my;
  } tick_t;

  typedef struct packed {
    logic              command_valid;
    logic [CHAN_W-1:0] pitch;
    logic [CHAN_W-1:0] yaw;
    logic              aim;
  } servo_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_manual_mode = 1'b0;
  logic in_target_valid = 1'b0;
  logic signed [15:0] in_error_x = '0;
  logic signed [15:0] in_error_y = '0;
  logic signed [15:0] in_manual_pitch = '0;
  logic signed [15:0] in_manual_yaw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_command_valid;
  logic [CHAN_W-1:0] out_pitch_channel;
  logic [CHAN_W-1:0] out_yaw_channel;
  logic out_aim_ok;

  // model state and configuration
  int kp_gain [2];
  int ki_gain [2];
  int kd_gain [2];
  int accum [2];
  int last_err [2];
  int int_limit;
  int aim_thr;

  // expected results in transfer order
  servo_cmd_t exp_buf [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  int mismatches = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  dual_axis_pid_servo_command dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_manual_mode    (in_manual_mode),
    .in_target_valid   (in_target_valid),
    .in_error_x        (in_error_x),
    .in_error_y        (in_error_y),
    .in_manual_pitch   (in_manual_pitch),
    .in_manual_yaw     (in_manual_yaw),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_command_valid (out_command_valid),
    .out_pitch_channel (out_pitch_channel),
    .out_yaw_channel   (out_yaw_channel),
    .out_aim_ok        (out_aim_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    kp_gain[AX_PITCH] = 27034;
    ki_gain[AX_PITCH] = 74;
    kd_gain[AX_PITCH] = 1761;
    kp_gain[AX_YAW]   = 32195;
    ki_gain[AX_YAW]   = 414;
    kd_gain[AX_YAW]   = 1393;
    int_limit = 640;
    aim_thr = 20;
    for (int a = 0; a < 2; a++) begin
      accum[a] = 0;
      last_err[a] = 0;
    end
  endfunction

  // one PID step on one axis, returns the saturated command
  function automatic int axis_pid_step(int ax, int err);
    int acc;
    longint sum;
    longint q;
    acc = accum[ax] + err;
    if (acc > int_limit) acc = int_limit;
    if (acc < -int_limit) acc = -int_limit;
    sum = longint'(kp_gain[ax]) * err + longint'(ki_gain[ax]) * acc
        + longint'(kd_gain[ax]) * (err - last_err[ax]);
    accum[ax] = acc;
    last_err[ax] = err;
    // signed division truncates toward zero
    q = sum / (longint'(1) << FRAC_BITS);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  // negate, add the dead-band offset and clamp to the servo range
  function automatic logic [CHAN_W-1:0] map_channel(int cmd, int up_off, int down_off);
    int v;
    v = -cmd;
    if (v > 0) v = v + up_off;
    else if (v == 0) v = CH_NEUTRAL;
    else v = v + down_off;
    if (v > CH_HIGH) v = CH_HIGH;
    if (v < CH_LOW) v = CH_LOW;
    return v[CHAN_W-1:0];
  endfunction

  function automatic servo_cmd_t predict_servo_cmd(bit manual, bit tvalid, int ex, int ey,
                                                   int mp, int my);
    servo_cmd_t r;
    if (manual) begin
      r.command_valid = 1'b1;
      r.pitch = map_channel(mp, PITCH_UP, PITCH_DOWN);
      r.yaw = map_channel(my, YAW_UP, YAW_DOWN);
      r.aim = 1'b0;
    end else begin
      if (tvalid) begin
        r.command_valid = 1'b1;
        r.pitch = map_channel(axis_pid_step(AX_PITCH, ey), PITCH_UP, PITCH_DOWN);
        r.yaw = map_channel(axis_pid_step(AX_YAW, ex), YAW_UP, YAW_DOWN);
      end else begin
        r.command_valid = 1'b0;
        r.pitch = CHAN_W'(CH_NEUTRAL);
        r.yaw = CHAN_W'(CH_NEUTRAL);
      end
      r.aim = (last_err[AX_PITCH] <= aim_thr);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitors
  // ---------------------------------------------------------------------------

  // register writes and input transfers feed the model
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_PITCH_KP:       kp_gain[AX_PITCH] = int'(cfg_data);
          REG_PITCH_KI:       ki_gain[AX_PITCH] = int'(cfg_data);
          REG_PITCH_KD:       kd_gain[AX_PITCH] = int'(cfg_data);
          REG_YAW_KP:         kp_gain[AX_YAW] = int'(cfg_data);
          REG_YAW_KI:         ki_gain[AX_YAW] = int'(cfg_data);
          REG_YAW_KD:         kd_gain[AX_YAW] = int'(cfg_data);
          REG_INTEGRAL_LIMIT: int_limit = int'(cfg_data[14:0]);
          REG_AIM_THRESHOLD:  aim_thr = int'($signed(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        exp_buf[exp_wr[11:0]] = predict_servo_cmd(in_manual_mode, in_target_valid,
                                                  int'(in_error_x), int'(in_error_y),
                                                  int'(in_manual_pitch),
                                                  int'(in_manual_yaw));
        exp_wr++;
      end
    end
  end

  // result transfers against the oldest expectation
  always @(posedge clk) begin : result_check
    servo_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (exp_rd == exp_wr) begin
        $error("result with no tick outstanding");
        mismatches++;
      end else begin
        want = exp_buf[exp_rd[11:0]];
        exp_rd++;
        if (out_command_valid !== want.command_valid) begin
          $error("command_valid: expected %0d, got %0d", want.command_valid, out_command_valid);
          mismatches++;
        end
        if (out_pitch_channel !== want.pitch) begin
          $error("pitch_channel: expected %0d, got %0d", want.pitch, out_pitch_channel);
          mismatches++;
        end
        if (out_yaw_channel !== want.yaw) begin
          $error("yaw_channel: expected %0d, got %0d", want.yaw, out_yaw_channel);
          mismatches++;
        end
        if (out_aim_ok !== want.aim) begin
          $error("aim_ok: expected %0d, got %0d", want.aim, out_aim_ok);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver back-pressure in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one tick transfer, with an optional gap in front of it
  task automatic send_tick(input bit manual, input bit tvalid, input int ex, input int ey,
                           input int mp, input int my);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_manual_mode <= manual;
    in_target_valid <= tvalid;
    in_error_x <= ex[15:0];
    in_error_y <= ey[15:0];
    in_manual_pitch <= mp[15:0];
    in_manual_yaw <= my[15:0];
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait until every tick in flight has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] p_kp, input logic [15:0] p_ki,
                              input logic [15:0] p_kd, input logic [15:0] y_kp,
                              input logic [15:0] y_ki, input logic [15:0] y_kd,
                              input logic [15:0] limit, input logic [15:0] thr);
    logic [15:0] vals [8];
    vals[REG_PITCH_KP] = p_kp;
    vals[REG_PITCH_KI] = p_ki;
    vals[REG_PITCH_KD] = p_kd;
    vals[REG_YAW_KP] = y_kp;
    vals[REG_YAW_KI] = y_ki;
    vals[REG_YAW_KD] = y_kd;
    vals[REG_INTEGRAL_LIMIT] = limit;
    vals[REG_AIM_THRESHOLD] = thr;
    drain();
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [15:0] pick_gain();
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 8191));
  endfunction

  // tracking error around a bias: mostly small, sometimes anywhere in range
  function automatic int pick_error(int bias);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 60) v = bias + $urandom_range(0, 64) - 32;
    else if (r < 85) v = bias + $urandom_range(0, 4095) - 2048;
    else return $signed(16'($urandom()));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic tick_t random_tick(int bias_x, int bias_y);
    tick_t t;
    int r;
    r = $urandom_range(0, 99);
    t.manual = (r < 12);
    t.tvalid = (r >= 25) ? 1'b1 : 1'($urandom());
    t.ex = 16'(pick_error(bias_x));
    t.ey = 16'(pick_error(bias_y));
    if ($urandom_range(0, 1) == 0) begin
      t.mp = 16'($urandom());
      t.my = 16'($urandom());
    end else begin
      t.mp = 16'($urandom_range(0, 2000) - 1000);
      t.my = 16'($urandom_range(0, 2000) - 1000);
    end
    return t;
  endfunction

  // a run of random ticks that share one error bias per stretch
  task automatic send_random(input int count);
    tick_t t;
    int bias_x;
    int bias_y;
    bias_x = 0;
    bias_y = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 25 == 0) begin
        bias_x = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 600) - 300;
        bias_y = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 600) - 300;
      end
      t = random_tick(bias_x, bias_y);
      send_tick(t.manual, t.tvalid, int'($signed(t.ex)), int'($signed(t.ey)),
                int'($signed(t.mp)), int'($signed(t.my)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // manual values pass through, errors and target bit are ignored
  task automatic test_manual_passthrough();
    send_tick(1'b1, 1'b0, 0, 0, 0, 0);
    send_tick(1'b1, 1'b1, 32767, -32768, 1, -1);
    send_tick(1'b1, 1'b1, -32768, 32767, 32767, -32768);
    send_tick(1'b1, 1'b0, 1, -1, -32768, 32767);
    send_tick(1'b1, 1'b1, 100, -100, -1000, 800);
  endtask

  // auto without a target holds the state and re-evaluates the aim flag
  task automatic test_idle_ticks();
    send_tick(1'b0, 1'b0, 32767, -32768, 0, 0);
    send_tick(1'b0, 1'b0, -1, -1, 5, 5);
  endtask

  // error extremes, sum saturation and the aim threshold boundary
  task automatic test_pid_extremes();
    send_tick(1'b0, 1'b1, 0, 0, 0, 0);
    send_tick(1'b0, 1'b1, 1, -1, 0, 0);
    send_tick(1'b0, 1'b1, -5, 20, 0, 0);
    send_tick(1'b0, 1'b1, 5, 21, 0, 0);
    send_tick(1'b0, 1'b0, 0, 0, 0, 0);
    send_tick(1'b0, 1'b1, -32768, 32767, 0, 0);
    send_tick(1'b0, 1'b1, 32767, -32768, 0, 0);
    send_tick(1'b0, 1'b1, 32767, 32767, 0, 0);
    send_tick(1'b0, 1'b1, -32768, -32768, 0, 0);
    send_tick(1'b1, 1'b1, 0, 0, 0, 0);
    send_tick(1'b0, 1'b0, 0, 0, 0, 0);
  endtask

  // zero gains, full gains with the widest limit, a zero limit, then the defaults again
  task automatic test_gain_corners();
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
    send_random(30);
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'hFFFF, 16'h7FFF);
    send_random(30);
    program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                 pick_gain(), 16'd0, 16'hFFEC);
    send_random(30);
    program_regs(16'd27034, 16'd74, 16'd1761, 16'd32195, 16'd414, 16'd1393,
                 16'd640, 16'd20);
    send_random(30);
  endtask

  // random ticks with a fresh register set every couple of hundred
  task automatic test_random_regression();
    logic [15:0] limit;
    logic [15:0] thr;
    for (int blk = 0; blk < 4; blk++) begin
      limit = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1000));
      thr = ($urandom_range(0, 2) == 0) ? 16'($urandom())
                                       : 16'($urandom_range(0, 128) - 64);
      program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                   pick_gain(), limit, thr);
      for (int c = 0; c < 5; c++) begin
        idle_on = ($urandom_range(0, 3) != 0);
        send_random(40);
      end
    end
    idle_on = 1'b1;
  endtask

  // back-to-back ticks with neither side idling
  task automatic test_steady_stream();
    drain();
    idle_on = 1'b0;
    send_random(100);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_manual_passthrough();
    test_idle_ticks();
    test_pid_extremes();
    test_gain_corners();
    test_random_regression();
    test_steady_stream();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/dapsc_pkg.sv
rtl/dapsc_pid_axis.sv
rtl/dapsc_channel.sv
rtl/dual_axis_pid_servo_command.sv
tb/tb_dual_axis_pid_servo_command.sv
